/* sv/pairwise_match_consistency_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the pairwise match consistency block
// Clocked on clk; the first form is gated by rst, the second is not.
// ---------------------------------------------------------------------------
`ifndef PAIRWISE_MATCH_CONSISTENCY_ASSERT_SVH
`define PAIRWISE_MATCH_CONSISTENCY_ASSERT_SVH

// Checked outside reset only.
`define PMC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define PMC_ASSERT_NR(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/pmc_pkg.sv */
// ---------------------------------------------------------------------------
// pmc_pkg
// Types and constants shared by the pairwise match consistency block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pmc_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int IDX_W      = 10;
  localparam int COORD_W    = 32;
  localparam int CFG_W      = 16;
  localparam int ROOT_W     = 33;  // root bits, one per sqrt stage
  localparam int RAD_W      = 65;  // dx^2 + dy^2
  localparam int DIFF_W     = 24;  // clamped |ds - dr|, max 2^23

  typedef enum logic [1:0] {
    REG_SIGMA  = 2'd0,
    REG_THRESH = 2'd1,
    REG_BINARY = 2'd2
  } pmc_reg_e;

  typedef struct packed {
    logic [IDX_W-1:0]          sample_idx_a;
    logic [IDX_W-1:0]          sample_idx_b;
    logic [IDX_W-1:0]          ref_idx_a;
    logic [IDX_W-1:0]          ref_idx_b;
    logic signed [COORD_W-1:0] sample_a_x;
    logic signed [COORD_W-1:0] sample_a_y;
    logic signed [COORD_W-1:0] sample_b_x;
    logic signed [COORD_W-1:0] sample_b_y;
    logic signed [COORD_W-1:0] ref_a_x;
    logic signed [COORD_W-1:0] ref_a_y;
    logic signed [COORD_W-1:0] ref_b_x;
    logic signed [COORD_W-1:0] ref_b_y;
  } pmc_pair_t;

  typedef struct packed {
    logic        edge_present;
    logic [15:0] edge_weight;
  } pmc_edge_t;

  typedef struct packed {
    logic [1:0]       index;
    logic [CFG_W-1:0] data;
  } pmc_cfg_word_t;

  typedef struct packed {
    logic [CFG_W-1:0] sigma_gain;
    logic [CFG_W-1:0] accept_threshold;
    logic             binary_mode;
  } pmc_cfg_t;

  typedef struct packed {
    logic              skip;
    logic [DIFF_W-1:0] diff;
  } pmc_mid_t;

endpackage

/* sv/pmc_in_if.sv */
// ---------------------------------------------------------------------------
// pmc_in_if
// Correspondence pair channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pmc_in_if;
  import pmc_pkg::*;
  logic      valid;
  logic      ready;
  pmc_pair_t word;
  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

/* sv/pmc_out_if.sv */
// ---------------------------------------------------------------------------
// pmc_out_if
// Edge result channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pmc_out_if;
  import pmc_pkg::*;
  logic      valid;
  logic      ready;
  pmc_edge_t word;
  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

/* sv/pmc_cfg_if.sv */
// ---------------------------------------------------------------------------
// pmc_cfg_if
// Register write channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pmc_cfg_if;
  import pmc_pkg::*;
  logic          valid;
  logic          ready;
  pmc_cfg_word_t word;
  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

/* sv/pmc_dist.sv */
// ---------------------------------------------------------------------------
// pmc_dist
// Index check, both point distances (pipelined bit-per-stage sqrt) and the
// clamped distance mismatch.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pmc_dist (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pmc_pkg::pmc_pair_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output pmc_pkg::pmc_mid_t   out_word
);
  import pmc_pkg::*;

  // stage 0 abs diffs, 1 squares, 2 sums, 3.. sqrt steps, last mismatch
  localparam int SQ0 = 3;
  localparam int NST = SQ0 + ROOT_W + 1;

  logic [NST-1:0] vld;
  logic [NST:0]   en;
  logic [NST-1:0] sk;

  assign en[NST] = out_ready;
  for (genvar k = 0; k < NST; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end
  assign in_ready  = en[0];
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b);
    logic [COORD_W:0] d;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    return d[COORD_W] ? COORD_W'(-d) : d[COORD_W-1:0];
  endfunction

  logic skip_in;
  assign skip_in = (in_word.sample_idx_a == in_word.sample_idx_b) ||
                   (in_word.ref_idx_a == in_word.ref_idx_b) ||
                   (32'(in_word.sample_idx_a) >= 32'(MAX_POINTS)) ||
                   (32'(in_word.sample_idx_b) >= 32'(MAX_POINTS)) ||
                   (32'(in_word.ref_idx_a) >= 32'(MAX_POINTS)) ||
                   (32'(in_word.ref_idx_b) >= 32'(MAX_POINTS));

  // lane 0 sample points, lane 1 reference points
  logic [COORD_W-1:0]   adx [2];
  logic [COORD_W-1:0]   ady [2];
  logic [2*COORD_W-1:0] sqx [2];
  logic [2*COORD_W-1:0] sqy [2];
  logic [RAD_W-1:0]     rad2 [2];

  logic [33:0]       rem_q  [2][ROOT_W];
  logic [ROOT_W-1:0] root_q [2][ROOT_W];
  logic [RAD_W-1:0]  rad_q  [2][ROOT_W];
  logic [35:0]       rem_next  [2][ROOT_W];
  logic [ROOT_W-1:0] root_next [2][ROOT_W];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sk[0]  <= skip_in;
      adx[0] <= abs_diff(in_word.sample_a_x, in_word.sample_b_x);
      ady[0] <= abs_diff(in_word.sample_a_y, in_word.sample_b_y);
      adx[1] <= abs_diff(in_word.ref_a_x, in_word.ref_b_x);
      ady[1] <= abs_diff(in_word.ref_a_y, in_word.ref_b_y);
    end
    if (en[1]) begin
      for (int ln = 0; ln < 2; ln++) begin
        sqx[ln] <= (2*COORD_W)'(adx[ln]) * (2*COORD_W)'(adx[ln]);
        sqy[ln] <= (2*COORD_W)'(ady[ln]) * (2*COORD_W)'(ady[ln]);
      end
    end
    if (en[2]) begin
      for (int ln = 0; ln < 2; ln++) begin
        rad2[ln] <= {1'b0, sqx[ln]} + {1'b0, sqy[ln]};
      end
    end
    for (int j = 0; j < ROOT_W; j++) begin
      if (en[SQ0+j]) begin
        for (int ln = 0; ln < 2; ln++) begin
          rem_q[ln][j]  <= rem_next[ln][j][33:0];
          root_q[ln][j] <= root_next[ln][j];
          rad_q[ln][j]  <= (j == 0) ? rad2[ln] : rad_q[ln][j-1];
        end
      end
    end
    for (int k = 1; k < NST; k++) begin
      if (en[k]) sk[k] <= sk[k-1];
    end
  end

  // Restoring square root, two radicand bits per stage, top pair first.
  for (genvar ln = 0; ln < 2; ln++) begin : g_lane
    for (genvar j = 0; j < ROOT_W; j++) begin : g_step
      localparam int I = ROOT_W - 1 - j;
      logic [33:0]       rem_in;
      logic [ROOT_W-1:0] root_in;
      logic [RAD_W:0]    rad_in;
      logic [35:0]       rem_sh;
      logic [35:0]       trial;
      logic              ge;
      if (j == 0) begin : g_first
        assign rem_in  = '0;
        assign root_in = '0;
        assign rad_in  = {1'b0, rad2[ln]};
      end else begin : g_next
        assign rem_in  = rem_q[ln][j-1];
        assign root_in = root_q[ln][j-1];
        assign rad_in  = {1'b0, rad_q[ln][j-1]};
      end
      assign rem_sh = {rem_in, rad_in[2*I+1 -: 2]};
      assign trial  = {1'b0, root_in, 2'b01};
      assign ge     = rem_sh >= trial;
      assign rem_next[ln][j]  = ge ? rem_sh - trial : rem_sh;
      assign root_next[ln][j] = {root_in[ROOT_W-2:0], ge};
    end
  end

  logic [ROOT_W-1:0] ds, dr, dd;
  assign ds = root_q[0][ROOT_W-1];
  assign dr = root_q[1][ROOT_W-1];
  assign dd = (ds >= dr) ? ds - dr : dr - ds;

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      out_word.skip <= sk[NST-2];
      out_word.diff <= (dd > ROOT_W'(1 << (DIFF_W-1))) ? DIFF_W'(1 << (DIFF_W-1))
                                                       : dd[DIFF_W-1:0];
    end
  end

endmodule

/* sv/pmc_exp.sv */
// ---------------------------------------------------------------------------
// pmc_exp
// Exponent from the mismatch, exp(-e) by series and eight squarings,
// threshold and weight, output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pmc_exp (
  input  logic               clk,
  input  logic               rst,
  input  pmc_pkg::pmc_cfg_t  cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  pmc_pkg::pmc_mid_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output pmc_pkg::pmc_edge_t out_word
);
  import pmc_pkg::*;

  localparam int NSQ    = 8;
  localparam int SQ0    = 10;
  localparam int NST    = SQ0 + NSQ + 1;
  localparam int DSQ_W  = 2 * DIFF_W - 1;
  localparam int P_W    = DSQ_W + CFG_W;
  localparam int E_W    = P_W - 24;
  localparam int S_W    = 27;
  localparam int PROD_W = 2 * S_W;
  localparam int RCP_W  = S_W + 32;

  logic [NST-1:0] vld;
  logic [NST:0]   en;
  logic [NST-1:0] sk;
  logic [NST-1:0] zr;

  assign en[NST] = out_ready;
  for (genvar k = 0; k < NST; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end
  assign in_ready  = en[0];
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  logic [DSQ_W-1:0]  dsq;
  logic [P_W-1:0]    p;
  logic [S_W-1:0]    s_q [2:SQ0-2];
  logic [PROD_W-1:0] sq3, prod4, prod6, prod7;
  logic [S_W-1:0]    t2_q [4:SQ0-2];
  logic [S_W-1:0]    t3_q [5:SQ0-2];
  logic [S_W-1:0]    t4_q [7:SQ0-2];
  logic [S_W-1:0]    t5;
  logic [31:0]       v9;
  logic [63:0]       sqp [NSQ];

  logic [E_W-1:0] e;
  logic [S_W-1:0] q3, q5;
  logic [RCP_W-1:0] r3, r5;
  logic [32:0]    v_sum;
  logic [31:0]    vin [NSQ];

  assign e  = E_W'((p + P_W'(1 << 23)) >> 24);
  assign q3 = S_W'(prod4 >> 31);
  assign r3 = RCP_W'(q3) * RCP_W'(32'hAAAA_AAAB);  // /3
  assign q5 = S_W'(prod7 >> 31);
  assign r5 = RCP_W'(q5) * RCP_W'(32'hCCCC_CCCD);  // /5
  assign v_sum = 33'(1 << 31) - 33'(s_q[SQ0-2]) + 33'(t2_q[SQ0-2]) - 33'(t3_q[SQ0-2])
               + 33'(t4_q[SQ0-2]) - 33'(t5);

  for (genvar k = 0; k < NSQ; k++) begin : g_vin
    if (k == 0) begin : g_first
      assign vin[k] = v9;
    end else begin : g_next
      assign vin[k] = 32'((sqp[k-1] + 64'(1 << 30)) >> 31);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sk[0] <= in_word.skip;
      dsq   <= DSQ_W'(in_word.diff) * DSQ_W'(in_word.diff);
    end
    if (en[1]) p <= P_W'(dsq) * P_W'(cfg.sigma_gain);
    if (en[2]) begin
      zr[2]  <= |e[E_W-1:20];              // e at or above 16.0
      s_q[2] <= {e[19:0], 7'b0};           // e/256 in Q1.31
    end
    if (en[3]) sq3 <= PROD_W'(s_q[2]) * PROD_W'(s_q[2]);
    if (en[4]) begin
      t2_q[4] <= S_W'(sq3 >> 32);
      prod4   <= PROD_W'(sq3 >> 32) * PROD_W'(s_q[3]);
    end
    if (en[5]) t3_q[5] <= S_W'(r3 >> 33);
    if (en[6]) prod6 <= PROD_W'(t3_q[5]) * PROD_W'(s_q[5]);
    if (en[7]) begin
      t4_q[7] <= S_W'(prod6 >> 33);
      prod7   <= PROD_W'(prod6 >> 33) * PROD_W'(s_q[6]);
    end
    if (en[8]) t5 <= S_W'(r5 >> 34);
    if (en[9]) v9 <= v_sum[31:0];
    for (int k = 0; k < NSQ; k++) begin
      if (en[SQ0+k]) sqp[k] <= 64'(vin[k]) * 64'(vin[k]);
    end
    for (int k = 3; k <= SQ0-2; k++) begin
      if (en[k]) s_q[k] <= s_q[k-1];
    end
    for (int k = 5; k <= SQ0-2; k++) begin
      if (en[k]) t2_q[k] <= t2_q[k-1];
    end
    for (int k = 6; k <= SQ0-2; k++) begin
      if (en[k]) t3_q[k] <= t3_q[k-1];
    end
    if (en[SQ0-2]) t4_q[SQ0-2] <= t4_q[SQ0-3];
    for (int k = 1; k < NST; k++) begin
      if (en[k]) sk[k] <= sk[k-1];
    end
    for (int k = 3; k < NST; k++) begin
      if (en[k]) zr[k] <= zr[k-1];
    end
  end

  logic [31:0] vf;
  logic [16:0] c17;
  logic [15:0] cons;
  logic        pres;
  assign vf   = 32'((sqp[NSQ-1] + 64'(1 << 30)) >> 31);
  assign c17  = 17'((33'(vf) + 33'(1 << 14)) >> 15);
  assign cons = zr[NST-2] ? 16'd0 : (c17[16] ? 16'hFFFF : c17[15:0]);
  assign pres = !sk[NST-2] && (cons > cfg.accept_threshold);

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      out_word.edge_present <= pres;
      out_word.edge_weight  <= pres ? (cfg.binary_mode ? 16'hFFFF : cons) : 16'd0;
    end
  end

endmodule

/* sv/pairwise_match_consistency.sv */
// ---------------------------------------------------------------------------
// pairwise_match_consistency
// Scores a pair of point correspondences and emits one edge word per pair.
// ---------------------------------------------------------------------------
//  channel | dir | word                        | accepted when
//  --------+-----+-----------------------------+---------------------
//  cfg     | in  | index[1:0], data[15:0]      | cfg.valid & ready
//  pairs   | in  | 4 indices, 8 Q16.16 coords  | pairs.valid & ready
//  edges   | out | edge_present, edge_weight   | edges.valid & ready
//
//  One pair word per cycle while edges is not stalled; a word passes the
//  distance pipe (one sqrt root bit per stage), then the exp pipe (at most
//  one multiply per stage, eight squaring stages) before its result word.
//  rst (synchronous) clears stage valids and loads register defaults.
//  A stall on edges back-pressures stage by stage; empty stages keep
//  filling, so pairs stays ready until the pipe is full.
//  cfg is always ready; registers are read live, write only when idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pairwise_match_consistency (
  input logic       clk,
  input logic       rst,
  pmc_cfg_if.sink   cfg,
  pmc_in_if.sink    pairs,
  pmc_out_if.source edges
);
  import pmc_pkg::*;

  pmc_cfg_t cfg_q;
  logic     mid_valid;
  logic     mid_ready;
  pmc_mid_t mid_word;

  assign cfg.ready = 1'b1;

  // Register file; indices past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.sigma_gain       <= 16'd256;
      cfg_q.accept_threshold <= 16'd32768;
      cfg_q.binary_mode      <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.word.index)
        REG_SIGMA:  cfg_q.sigma_gain       <= cfg.word.data;
        REG_THRESH: cfg_q.accept_threshold <= cfg.word.data;
        REG_BINARY: cfg_q.binary_mode      <= cfg.word.data[0];
        default: ;
      endcase
    end
  end

  // Front half: index check, distances, clamped mismatch.
  pmc_dist u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pairs.valid),
    .in_ready  (pairs.ready),
    .in_word   (pairs.word),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_word  (mid_word)
  );

  // Back half: exponent, exp(-e), threshold, output register.
  pmc_exp u_exp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_q),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_word   (mid_word),
    .out_valid (edges.valid),
    .out_ready (edges.ready),
    .out_word  (edges.word)
  );

endmodule

/* sv/pmc_checker.sv */
// ---------------------------------------------------------------------------
// pmc_checker
// Port-level checks on the result channel and pairs ready, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pairwise_match_consistency_assert.svh"

module pmc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input pmc_pkg::pmc_edge_t out_word
);
  import pmc_pkg::*;

  `PMC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_word), "stalled result word changed")
  `PMC_ASSERT(a_no_edge_zero, out_valid && !out_word.edge_present |-> out_word.edge_weight == 16'd0, "weight without edge")
  `PMC_ASSERT(a_empty_ready, !out_valid |-> in_ready, "input blocked with empty output")
  `PMC_ASSERT_NR(a_rst_clear, rst |=> !out_valid, "result valid after reset")

endmodule

bind pairwise_match_consistency pmc_checker u_pmc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (pairs.ready),
  .out_valid (edges.valid),
  .out_ready (edges.ready),
  .out_word  (edges.word)
);

/* test/pairwise_match_consistency_tb.sv */
// ---------------------------------------------------------------------------
// pairwise_match_consistency_tb
// Drives correspondence pairs and register writes into the consistency
// scorer, predicts every edge word in a local fixed-point model and checks
// each result in order, with random idling on both channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pairwise_match_consistency_tb;
  import pmc_pkg::*;

  localparam int LATENCY     = 56;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;

  pmc_cfg_if cfg ();
  pmc_in_if  pairs ();
  pmc_out_if edges ();

  pairwise_match_consistency dut (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg.sink),
    .pairs (pairs.sink),
    .edges (edges.source)
  );

  // Shadow copy of the block registers
  logic [15:0] sigma_q;
  logic [15:0] thresh_q;
  logic        binary_q;

  pmc_edge_t edge_q[$];
  int        errors;
  int        cycles;
  int        stall_cnt; // remaining cycles of a result-side stall burst
  bit        quiet;     // no idling near the end of the run

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on a cycle count
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // floor(sqrt(dx^2 + dy^2)) in Q.16, from the exact 66-bit squared sum
  function automatic logic [32:0] dist_q16(logic signed [31:0] ax, logic signed [31:0] ay,
                                           logic signed [31:0] bx, logic signed [31:0] by);
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic [65:0] rad;
    logic [67:0] rem;
    logic [67:0] trial;
    logic [33:0] root;
    dx = ax - bx;
    dy = ay - by;
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    rad = 66'(dx) * 66'(dx) + 66'(dy) * 66'(dy);
    rem = '0;
    root = '0;
    for (int i = 32; i >= 0; i--) begin
      rem = (rem << 2) | 68'(rad[2*i +: 2]);
      trial = (68'(root) << 2) | 68'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 34'd1;
      end else begin
        root = root << 1;
      end
    end
    return root[32:0];
  endfunction

  // exp(-e), e in Q16.16, result Q0.16 saturated
  function automatic logic [15:0] neg_exp_q16(logic [63:0] e);
    logic [63:0] s;
    logic [63:0] t;
    logic [63:0] v;
    if (e >= (64'd16 << 16)) return 16'd0;
    s = e << 7;
    v = 64'd1 << 31;
    t = s;
    for (int k = 1; k <= 5; k++) begin
      if (k > 1) t = ((t * s) >> 31) / k;
      if (k[0]) v = v - t;
      else      v = v + t;
    end
    for (int n = 0; n < 8; n++) v = (v * v + (64'd1 << 30)) >> 31;
    v = (v + (64'd1 << 14)) >> 15;
    return (v > 64'd65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic pmc_edge_t score_pair(pmc_pair_t p);
    pmc_edge_t   r;
    logic [32:0] ds;
    logic [32:0] dr;
    logic [63:0] diff;
    logic [63:0] e;
    logic [15:0] cons;
    r = '0;
    if (p.sample_idx_a == p.sample_idx_b || p.ref_idx_a == p.ref_idx_b) return r;
    ds = dist_q16(p.sample_a_x, p.sample_a_y, p.sample_b_x, p.sample_b_y);
    dr = dist_q16(p.ref_a_x, p.ref_a_y, p.ref_b_x, p.ref_b_y);
    diff = (ds > dr) ? 64'(ds - dr) : 64'(dr - ds);
    if (diff > (64'd1 << 23)) diff = 64'd1 << 23;
    e = (diff * diff * 64'(sigma_q) + (64'd1 << 23)) >> 24;
    cons = neg_exp_q16(e);
    if (cons > thresh_q) begin
      r.edge_present = 1'b1;
      r.edge_weight  = binary_q ? 16'hFFFF : cons;
    end
    return r;
  endfunction

  // Random idle burst, sometimes, with valid dropped (drain drops it too)
  task automatic maybe_idle();
    int n;
    n = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
    if (n > 0) begin
      pairs.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // ---- result side: random stall bursts, in-order compare ----
  always @(posedge clk) begin
    if (rst) begin
      edges.ready <= 1'b0;
      stall_cnt   <= 0;
    end else begin
      if (edges.valid && edges.ready) begin
        if (edge_q.size() == 0) begin
          $error("edge word with nothing expected");
          errors++;
        end else begin
          pmc_edge_t want;
          want = edge_q.pop_front();
          if (edges.word.edge_present !== want.edge_present) begin
            $error("edge_present: expected %0d, got %0d",
                   want.edge_present, edges.word.edge_present);
            errors++;
          end
          if (edges.word.edge_weight !== want.edge_weight) begin
            $error("edge_weight: expected %0d, got %0d",
                   want.edge_weight, edges.word.edge_weight);
            errors++;
          end
        end
      end
      // Random stall bursts, none when quiet
      if (quiet) begin
        edges.ready <= 1'b1;
      end else if (stall_cnt != 0) begin
        stall_cnt <= stall_cnt - 1;
      end else if ($urandom_range(0, 7) == 0) begin
        edges.ready <= 1'b0;
        stall_cnt   <= $urandom_range(0, 15);
      end else begin
        edges.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(pmc_reg_e idx, logic [15:0] data);
    cfg.valid      <= 1'b1;
    cfg.word.index <= idx;
    cfg.word.data  <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    case (idx)
      REG_SIGMA:  sigma_q  = data;
      REG_THRESH: thresh_q = data;
      REG_BINARY: binary_q = data[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Wait until all results are back, plus pipeline drain
  task automatic drain();
    pairs.valid <= 1'b0;
    while (edge_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  // Present one pair word; the prediction is taken at acceptance.
  // has_want marks directed rows with a hand-read result.
  task automatic send_pair(pmc_pair_t p, bit has_want, pmc_edge_t want);
    pmc_edge_t pred;
    pairs.valid <= 1'b1;
    pairs.word  <= p;
    @(posedge clk);
    while (!pairs.ready) @(posedge clk);
    pred = score_pair(p);
    if (has_want && pred !== want) begin
      $error("edge_weight: expected %0d, got %0d (directed row)",
             want.edge_weight, pred.edge_weight);
      errors++;
    end
    edge_q.insert(edge_q.size(), has_want ? want : pred);
    maybe_idle();
  endtask

  function automatic logic signed [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000;
      default: return $signed($urandom_range(0, 32'h0001_0000)) - 32'sh0000_8000;
    endcase
  endfunction

  // Random pair; often its two distances are close, so exp lands between 0 and 1
  function automatic pmc_pair_t rand_pair();
    pmc_pair_t p;
    int mode;
    int off;
    mode = $urandom_range(0, 9) == 0 ? 0 : ($urandom_range(0, 1) ? 1 : 2);
    p.sample_idx_a = 10'($urandom);
    p.sample_idx_b = 10'($urandom);
    p.ref_idx_a    = 10'($urandom);
    p.ref_idx_b    = 10'($urandom);
    if ($urandom_range(0, 15) == 0) p.sample_idx_b = p.sample_idx_a;
    if ($urandom_range(0, 15) == 0) p.ref_idx_b = p.ref_idx_a;
    p.sample_a_x = rand_coord(mode);
    p.sample_a_y = rand_coord(mode);
    p.sample_b_x = rand_coord(mode);
    p.sample_b_y = rand_coord(mode);
    if (mode != 0 && $urandom_range(0, 3) != 0) begin
      // Rigid shift of the sample pair plus a small jitter
      off = $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
      p.ref_a_x = p.sample_a_x + off;
      p.ref_a_y = p.sample_a_y - off;
      p.ref_b_x = p.sample_b_x + off + ($signed($urandom_range(0, 32'h8000)) - 16384);
      p.ref_b_y = p.sample_b_y - off + ($signed($urandom_range(0, 32'h8000)) - 16384);
    end else begin
      p.ref_a_x = rand_coord(mode);
      p.ref_a_y = rand_coord(mode);
      p.ref_b_x = rand_coord(mode);
      p.ref_b_y = rand_coord(mode);
    end
    return p;
  endfunction

  // Directed rows: pair word, whether the result is typed in, and that result
  typedef struct {
    pmc_pair_t p;
    bit        has_want;
    pmc_edge_t want;
  } pair_row_t;

  function automatic pmc_pair_t mk(logic [9:0] sa, logic [9:0] sb, logic [9:0] ra,
                                   logic [9:0] rb, logic signed [31:0] c0,
                                   logic signed [31:0] c1, logic signed [31:0] c2,
                                   logic signed [31:0] c3);
    pmc_pair_t p;
    p = '{sa, sb, ra, rb, c0, c1, c2, c3, c0, c1, c2, c3};
    return p;
  endfunction

  pair_row_t rows[$];
  pmc_pair_t p;

  task automatic add_row(pmc_pair_t rp, bit has_want, pmc_edge_t want);
    pair_row_t r;
    r.p        = rp;
    r.has_want = has_want;
    r.want     = want;
    rows.insert(rows.size(), r);
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    quiet  = 1'b0;
    rst    = 1'b1;
    cfg.valid   = 1'b0;
    cfg.word    = '0;
    pairs.valid = 1'b0;
    pairs.word  = '0;
    edges.ready = 1'b0;
    sigma_q  = 16'd256;
    thresh_q = 16'd32768;
    binary_q = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: identical geometry gives consistency 1.0 (saturated)
    add_row(mk(0, 1, 2, 3, 0, 0, 32'sh10000, 0), 1, '{1'b1, 16'hFFFF});
    // Shared sample index, shared reference index: no edge
    add_row(mk(5, 5, 2, 3, 0, 0, 1, 1), 1, '{1'b0, 16'h0});
    add_row(mk(5, 6, 9, 9, 0, 0, 1, 1), 1, '{1'b0, 16'h0});
    // Index extremes
    add_row(mk(10'h3FF, 0, 0, 10'h3FF, 32'sh7FFFFFFF, 32'sh80000000,
               32'sh80000000, 32'sh7FFFFFFF), 1, '{1'b1, 16'hFFFF});
    // Large mismatch: sample far apart, references coincide
    p = mk(1, 2, 3, 4, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000);
    p.ref_b_x = p.ref_a_x;
    p.ref_b_y = p.ref_a_y;
    add_row(p, 1, '{1'b0, 16'h0});
    // Small mismatches around the threshold, predicted
    for (int i = 0; i < 6; i++) begin
      p = mk(1, 2, 3, 4, 0, 0, 32'sh30000, 0);
      p.ref_b_x = 32'sh30000 + i * 32'sh4000;
      add_row(p, 0, '{1'b0, 16'h0});
    end
    foreach (rows[i]) send_pair(rows[i].p, rows[i].has_want, rows[i].want);
    drain();

    // Zero sigma: any geometry saturates to full consistency
    write_reg(REG_SIGMA, 16'd0);
    send_pair(p, 1, '{1'b1, 16'hFFFF});
    drain();

    // Register extremes, then random traffic across several settings
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin write_reg(REG_SIGMA, 16'hFFFF); write_reg(REG_THRESH, 16'h0000);
                 write_reg(REG_BINARY, 16'd0); end
        1: begin write_reg(REG_THRESH, 16'hFFFF); write_reg(REG_SIGMA, 16'd256); end
        2: begin write_reg(REG_BINARY, 16'd1); write_reg(REG_THRESH, 16'd1000); end
        3: begin write_reg(REG_SIGMA, 16'd1); write_reg(REG_THRESH, 16'hFFFE); end
        4: begin write_reg(REG_BINARY, 16'd0); write_reg(REG_SIGMA, 16'd4096);
                 write_reg(REG_THRESH, 16'd0); end
        default: begin write_reg(REG_SIGMA, 16'($urandom));
                       write_reg(REG_THRESH, 16'($urandom));
                       write_reg(REG_BINARY, 16'($urandom_range(0, 1))); end
      endcase
      quiet = (phase == 7);
      for (int n = 0; n < 50; n++) send_pair(rand_pair(), 0, '{1'b0, 16'h0});
      drain();
    end

    if (errors == 0) $display("Testbench completed without errors");
    else             $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
